### sv/tpbpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tpbpa_pkg;

   localparam int PAGE_W = 52;
   localparam int CNT_W = 11;
   localparam int CSR_W = 52;

   localparam logic [1:0] CSR_KBASE = 2'd0;
   localparam logic [1:0] CSR_KTOTAL = 2'd1;
   localparam logic [1:0] CSR_UBASE = 2'd2;
   localparam logic [1:0] CSR_UTOTAL = 2'd3;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE = 1'b1;

   typedef enum logic [2:0] {
      ST_OK = 3'd0,
      ST_NO_PAGES = 3'd1,
      ST_NOT_IN_POOL = 3'd2,
      ST_PAST_END = 3'd3,
      ST_NOT_ALLOCATED = 3'd4
   } status_type;

endpackage
`default_nettype wire

### sv/two_pool_bitmap_page_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// Two-pool bitmap page allocator, first fit.
// The req_ channel takes one request item; the rsp_ channel returns exactly one
// result item for it. The user must make configuration writes on csr_ only while
// the block is idle; the block itself does not enforce this. Each pool's used map
// lives in a synchronous memory of one bit per page, one entry per page. Every
// request is handled by a sequencer that reads one entry per cycle (the read data
// is registered) and writes one entry per cycle.
// Allocate: scans entries 0..total-1 until a run of page_count free pages is
// found, then writes the run back as used.
// Free: a check pass over the run, then a clearing pass; the clearing pass is
// skipped when a page of the run is not allocated.
// A zero page count or a rejected range is answered straight from decode.
// The per-page memory access is what sets the rate.
// After reset a clearing pass marks every page of both maps used; during this
// pass req_tready stays low.
// The result waits in an output register; while the receiver stalls, no new
// request is taken. One request is in the block at a time.
module two_pool_bitmap_page_allocator #(
   parameter int POOL_PAGES = 1024
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // func, use_user_pool, zero_fill, page_count[10:0], page_number[51:0], pad
   input  wire  [71:0]                      req_tdata,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // status[2:0], granted_page[51:0], zero_needed
   output logic [55:0]                      rsp_tdata,
   input  wire                              csr_wen,
   input  wire  [1:0]                       csr_index,
   input  wire  [tpbpa_pkg::CSR_W-1:0]      csr_wdata
);
   import tpbpa_pkg::*;

   localparam int AW = $clog2(POOL_PAGES);
   localparam int TW = AW + 1;
   localparam logic [TW-1:0] POOL_MAX = TW'(POOL_PAGES);

   typedef enum logic [8:0] {
      S_INIT = 9'b000000001,
      S_IDLE = 9'b000000010,
      S_DEC = 9'b000000100,
      S_SCAN = 9'b000001000,
      S_MARK = 9'b000010000,
      S_CHK = 9'b000100000,
      S_CLR = 9'b001000000,
      S_RSP = 9'b010000000,
      S_FMAP = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [PAGE_W-1:0] kbase_ff, ubase_ff;
   logic [CNT_W-1:0] ktot_ff, utot_ff;

   logic op_ff, pool_ff, zf_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [PAGE_W-1:0] pg_ff;

   logic op_in, pool_in, zf_in;
   logic [CNT_W-1:0] cnt_in;
   logic [PAGE_W-1:0] pg_in;

   logic [TW-1:0] addr_ff, addr_in;     // next read address
   logic [TW-1:0] start_ff, start_in;   // run start / current write index
   logic [TW-1:0] end_ff, end_in;       // exclusive end index
   logic [CNT_W-1:0] run_ff, run_in;
   logic rd_pend_ff, rd_pend_in;        // a read is in flight
   logic [PAGE_W-1:0] base_ff, base_in;

   logic [2:0] st_ff, st_in;
   logic [PAGE_W-1:0] gr_ff, gr_in;
   logic zn_ff, zn_in;
   logic rv_ff, rv_in;

   logic kmem [POOL_PAGES];
   logic umem [POOL_PAGES];
   logic krd_ff, urd_ff;
   logic rd_en, wr_en, wr_bit, wr_k, wr_u;
   logic [AW-1:0] rd_addr, wr_addr;
   logic rd_bit;

   logic [TW-1:0] ktot_eff, utot_eff, tot_sel;
   logic [PAGE_W:0] kend, uend;
   logic k_hit, u_hit;
   logic [PAGE_W-1:0] idx_full;
   logic [PAGE_W:0] idx_end;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         krd_ff <= kmem[rd_addr];
         urd_ff <= umem[rd_addr];
      end
      if (wr_en && wr_k) kmem[wr_addr] <= wr_bit;
      if (wr_en && wr_u) umem[wr_addr] <= wr_bit;
   end

   assign rd_bit = pool_ff ? urd_ff : krd_ff;
   assign rd_addr = addr_ff[AW-1:0];

   always_comb begin
      ktot_eff = ({{(TW > CNT_W ? TW - CNT_W : 0){1'b0}}, ktot_ff} > POOL_MAX) ?
                 POOL_MAX : TW'(ktot_ff);
      utot_eff = ({{(TW > CNT_W ? TW - CNT_W : 0){1'b0}}, utot_ff} > POOL_MAX) ?
                 POOL_MAX : TW'(utot_ff);
      kend = {1'b0, kbase_ff} + (PAGE_W + 1)'(ktot_eff);
      uend = {1'b0, ubase_ff} + (PAGE_W + 1)'(utot_eff);
      k_hit = (pg_ff >= kbase_ff) && ({1'b0, pg_ff} < kend);
      u_hit = (pg_ff >= ubase_ff) && ({1'b0, pg_ff} < uend);
      idx_full = pg_ff - (k_hit ? kbase_ff : ubase_ff);
      idx_end = {1'b0, idx_full} + (PAGE_W + 1)'(cnt_ff);
      tot_sel = k_hit ? ktot_eff : utot_eff;
   end

   always_comb begin
      state_in = state_ff;
      op_in = op_ff; pool_in = pool_ff; zf_in = zf_ff; cnt_in = cnt_ff; pg_in = pg_ff;
      addr_in = addr_ff; start_in = start_ff; end_in = end_ff; run_in = run_ff;
      rd_pend_in = 1'b0; base_in = base_ff;
      st_in = st_ff; gr_in = gr_ff; zn_in = zn_ff; rv_in = rv_ff;
      rd_en = 1'b0; wr_en = 1'b0; wr_bit = 1'b1; wr_k = 1'b0; wr_u = 1'b0;
      wr_addr = start_ff[AW-1:0];
      req_tready = 1'b0;

      if (rv_ff && rsp_tready) rv_in = 1'b0;

      case (state_ff)
         S_INIT: begin
            wr_en = 1'b1; wr_k = 1'b1; wr_u = 1'b1; wr_bit = 1'b1;
            start_in = start_ff + 1'b1;
            if (start_ff == POOL_MAX - 1'b1) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_tready = !rv_ff;
            if (req_tvalid && !rv_ff) begin
               op_in = req_tdata[0];
               pool_in = req_tdata[1];
               zf_in = req_tdata[2];
               cnt_in = req_tdata[13:3];
               pg_in = req_tdata[65:14];
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            st_in = ST_OK; gr_in = '0; zn_in = 1'b0;
            addr_in = '0; start_in = '0; run_in = '0;
            if (cnt_ff == '0) begin
               state_in = S_RSP;
            end else if (op_ff == FUNC_ALLOC) begin
               base_in = pool_ff ? ubase_ff : kbase_ff;
               end_in = pool_ff ? utot_eff : ktot_eff;
               state_in = S_SCAN;
            end else if (!k_hit && !u_hit) begin
               st_in = ST_NOT_IN_POOL;
               state_in = S_RSP;
            end else if (idx_end > (PAGE_W + 1)'(tot_sel)) begin
               st_in = ST_PAST_END;
               state_in = S_RSP;
            end else begin
               pool_in = !k_hit;
               addr_in = TW'(idx_full);
               start_in = TW'(idx_full);
               end_in = TW'(idx_end);
               state_in = S_FMAP;
            end
         end
         S_FMAP: begin
            // Pool chosen for the free; reads begin next.
            state_in = S_CHK;
         end
         S_SCAN: begin
            // Issue reads ahead; act on the bit returned from the previous read.
            if (rd_pend_ff) begin
               if (rd_bit) begin
                  run_in = '0;
                  start_in = addr_ff;
               end else begin
                  run_in = run_ff + 1'b1;
               end
            end
            if (rd_pend_ff && !rd_bit) begin
               if (run_ff + 1'b1 == cnt_ff) begin
                  gr_in = base_ff + PAGE_W'(start_ff);
                  zn_in = zf_ff;
                  end_in = start_ff + TW'(cnt_ff);
                  state_in = S_MARK;
               end
            end
            if (state_in == S_SCAN) begin
               if (addr_ff < end_ff) begin
                  rd_en = 1'b1;
                  rd_pend_in = 1'b1;
                  addr_in = addr_ff + 1'b1;
               end else if (!rd_pend_ff || rd_bit || run_ff + 1'b1 != cnt_ff) begin
                  if (!rd_pend_ff) begin
                     st_in = ST_NO_PAGES;
                     state_in = S_RSP;
                  end
               end
            end
         end
         S_MARK: begin
            wr_en = 1'b1; wr_bit = 1'b1; wr_k = !pool_ff; wr_u = pool_ff;
            start_in = start_ff + 1'b1;
            if (start_ff + 1'b1 == end_ff) state_in = S_RSP;
         end
         S_CHK: begin
            if (rd_pend_ff && !rd_bit) st_in = ST_NOT_ALLOCATED;
            if (addr_ff < end_ff) begin
               rd_en = 1'b1;
               rd_pend_in = 1'b1;
               addr_in = addr_ff + 1'b1;
            end else if (!rd_pend_ff) begin
               state_in = (st_ff == ST_OK) ? S_CLR : S_RSP;
            end
         end
         S_CLR: begin
            wr_en = 1'b1; wr_bit = 1'b0; wr_k = !pool_ff; wr_u = pool_ff;
            start_in = start_ff + 1'b1;
            if (start_ff + 1'b1 == end_ff) state_in = S_RSP;
         end
         S_RSP: begin
            rv_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         rv_ff <= 1'b0;
         rd_pend_ff <= 1'b0;
         start_ff <= '0;
         kbase_ff <= '0; ubase_ff <= '0; ktot_ff <= '0; utot_ff <= '0;
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
         rd_pend_ff <= rd_pend_in;
         start_ff <= start_in;
         if (csr_wen) begin
            case (csr_index)
               CSR_KBASE: kbase_ff <= csr_wdata[PAGE_W-1:0];
               CSR_KTOTAL: ktot_ff <= csr_wdata[CNT_W-1:0];
               CSR_UBASE: ubase_ff <= csr_wdata[PAGE_W-1:0];
               CSR_UTOTAL: utot_ff <= csr_wdata[CNT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in; pool_ff <= pool_in; zf_ff <= zf_in; cnt_ff <= cnt_in;
      pg_ff <= pg_in; addr_ff <= addr_in; end_ff <= end_in; run_ff <= run_in;
      base_ff <= base_in; st_ff <= st_in; gr_ff <= gr_in; zn_ff <= zn_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = {zn_ff, gr_ff, st_ff};

endmodule
`default_nettype wire

### sv/tpbpa_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module tpbpa_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire [71:0] req_tdata,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [55:0] rsp_tdata
);
   import tpbpa_pkg::*;

   // One request in the block at a time: no request taken while a result waits.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("request taken while result pending");

   // Status codes beyond the defined set never appear.
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[2:0] <= ST_NOT_ALLOCATED)) else $error("bad status");

   // A failed item never grants a page or asks for zeroing.
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[2:0] != ST_OK) |-> (rsp_tdata[55:3] == '0))
      else $error("failed item carries a grant");

   // A stalled result holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result changed under stall");
endmodule

bind two_pool_bitmap_page_allocator tpbpa_checker u_tpbpa_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .req_tdata(req_tdata), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata)
);
`default_nettype wire

### test/two_pool_bitmap_page_allocator_tb.sv
`timescale 1ns / 1ps
module two_pool_bitmap_page_allocator_tb;
   import tpbpa_pkg::*;

   localparam int MAP_PAGES = 1024;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int LONG_HOLD = 300;
   localparam longint unsigned MASK52 = (64'd1 << 52) - 1;

   typedef struct {
      status_type         status;
      logic [PAGE_W-1:0]  granted_page;
      logic               zero_needed;
   } alloc_result_type;

   class page_alloc_scoreboard;
      bit kernel_used[MAP_PAGES];
      bit user_used[MAP_PAGES];
      longint unsigned kernel_base, kernel_total, user_base, user_total;
      alloc_result_type pending_results[$];
      int errors;

      function void clear();
         foreach (kernel_used[i]) begin
            kernel_used[i] = 1'b1;
            user_used[i] = 1'b1;
         end
         kernel_base = 0;
         kernel_total = 0;
         user_base = 0;
         user_total = 0;
         errors = 0;
      endfunction

      function void set_register(logic [1:0] index, longint unsigned value);
         case (index)
            CSR_KBASE: kernel_base = value & MASK52;
            CSR_KTOTAL: kernel_total = value & 64'h7ff;
            CSR_UBASE: user_base = value & MASK52;
            default: user_total = value & 64'h7ff;
         endcase
      endfunction

      function longint unsigned clamp(longint unsigned total);
         return (total > MAP_PAGES) ? MAP_PAGES : total;
      endfunction

      // Works out the answer to one accepted request and updates the maps.
      function void note_request(logic [71:0] data);
         logic func, pick_user, zf;
         longint unsigned cnt, pg, base, total, run, found, idx;
         bit ok, in_kernel;
         alloc_result_type res;
         func = data[0];
         pick_user = data[1];
         zf = data[2];
         cnt = data[13:3];
         pg = data[65:14];
         res.status = ST_OK;
         res.granted_page = '0;
         res.zero_needed = 1'b0;
         if (cnt != 0) begin
            if (func == FUNC_ALLOC) begin
               base = pick_user ? user_base : kernel_base;
               total = clamp(pick_user ? user_total : kernel_total);
               run = 0;
               ok = 0;
               for (int i = 0; i < total; i++) begin
                  run = (pick_user ? user_used[i] : kernel_used[i]) ? 0 : run + 1;
                  if (run == cnt) begin
                     found = i + 1 - cnt;
                     ok = 1;
                     break;
                  end
               end
               if (ok) begin
                  for (longint unsigned i = found; i < found + cnt; i++)
                     if (pick_user) user_used[i] = 1'b1;
                     else kernel_used[i] = 1'b1;
                  res.granted_page = PAGE_W'((base + found) & MASK52);
                  res.zero_needed = zf;
               end else begin
                  res.status = ST_NO_PAGES;
               end
            end else begin
               // The kernel pool wins when the two pools overlap.
               in_kernel = pg >= kernel_base && pg < kernel_base + clamp(kernel_total);
               if (in_kernel) begin
                  base = kernel_base;
                  total = clamp(kernel_total);
               end else if (pg >= user_base && pg < user_base + clamp(user_total)) begin
                  base = user_base;
                  total = clamp(user_total);
               end else begin
                  res.status = ST_NOT_IN_POOL;
               end
               if (res.status == ST_OK) begin
                  idx = pg - base;
                  if (idx + cnt > total) begin
                     res.status = ST_PAST_END;
                  end else begin
                     for (longint unsigned i = idx; i < idx + cnt; i++)
                        if (!(in_kernel ? kernel_used[i] : user_used[i]))
                           res.status = ST_NOT_ALLOCATED;
                     if (res.status == ST_OK)
                        for (longint unsigned i = idx; i < idx + cnt; i++)
                           if (in_kernel) kernel_used[i] = 1'b0;
                           else user_used[i] = 1'b0;
                  end
               end
            end
         end
         pending_results.push_back(res);
      endfunction

      function void check_response(logic [55:0] data);
         alloc_result_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result item %h", $time, data);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         if (data[2:0] != want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, data[2:0]);
            errors++;
         end
         if (data[54:3] != want.granted_page) begin
            $display("%0t: granted_page expected %h actual %h", $time,
                     want.granted_page, data[54:3]);
            errors++;
         end
         if (data[55] != want.zero_needed) begin
            $display("%0t: zero_needed expected %b actual %b", $time,
                     want.zero_needed, data[55]);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [71:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic csr_wen = 1'b0;
   logic [1:0] csr_index = CSR_KBASE;
   logic [CSR_W-1:0] csr_wdata = '0;

   page_alloc_scoreboard sb = new();
   bit hold_request = 0;
   int idle_cycles = 0;

   two_pool_bitmap_page_allocator i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Receiver: random stalls, plus one long hold-off when asked.
   always @(negedge clock) begin
      if (hold_request) begin
         rsp_tready <= 1'b0;
         hold_request = 0;
         repeat (LONG_HOLD) @(negedge clock);
      end else if (!rsp_tready) begin
         rsp_tready <= ($urandom_range(0, 3) != 0);
      end else if ($urandom_range(0, 9) == 0) begin
         rsp_tready <= 1'b0;
         repeat (pick_gap()) @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   task automatic write_register(logic [1:0] index, longint unsigned value);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_index <= index;
      csr_wdata <= value[CSR_W-1:0];
      sb.set_register(index, value);
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   // The last item may still be offered; withdraw it before waiting.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic configure(longint unsigned kb, longint unsigned kt,
                            longint unsigned ub, longint unsigned ut);
      drain();
      write_register(CSR_KBASE, kb);
      write_register(CSR_KTOTAL, kt);
      write_register(CSR_UBASE, ub);
      write_register(CSR_UTOTAL, ut);
   endtask

   // Offers one request; valid stays high into the next item when no gap follows.
   task automatic send_request(logic func, logic pick_user, logic zf,
                               longint unsigned cnt, longint unsigned pg);
      int gap;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {6'b0, pg[51:0], cnt[10:0], zf, pick_user, func};
      do @(posedge clock); while (!req_tready);
      sb.note_request(req_tdata);
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic random_items(int count);
      int r;
      longint unsigned base, total;
      logic pool;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         pool = 1'($urandom_range(0, 1));
         if (r < 10) begin
            send_request(1'($urandom_range(0, 1)), pool, 1'($urandom_range(0, 1)),
                         $urandom_range(0, 2047), {$urandom, $urandom} & MASK52);
         end else if (r < 55) begin
            send_request(FUNC_ALLOC, pool, 1'($urandom_range(0, 1)),
                         ($urandom_range(0, 9) == 0) ? $urandom_range(1, 24)
                                                     : $urandom_range(1, 6), 0);
         end else begin
            base = pool ? sb.user_base : sb.kernel_base;
            total = sb.clamp(pool ? sb.user_total : sb.kernel_total);
            send_request(FUNC_FREE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         $urandom_range(1, 6),
                         (base + $urandom_range(0, total + 1)) & MASK52);
         end
      end
   endtask

   initial begin
      sb.clear();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      configure(0, 16, 100, 24);
      send_request(FUNC_ALLOC, 0, 1, 1, 0);
      send_request(FUNC_ALLOC, 0, 1, 0, 0);
      send_request(FUNC_FREE, 0, 1, 0, 5);
      send_request(FUNC_FREE, 0, 0, 16, 0);
      send_request(FUNC_FREE, 0, 0, 17, 0);
      send_request(FUNC_FREE, 0, 0, 1, 50);
      send_request(FUNC_FREE, 0, 0, 1, 0);
      send_request(FUNC_ALLOC, 0, 1, 16, 0);
      send_request(FUNC_ALLOC, 0, 0, 17, 0);
      send_request(FUNC_FREE, 0, 0, 24, 100);
      send_request(FUNC_ALLOC, 1, 0, 3, 0);
      send_request(FUNC_ALLOC, 1, 1, 2047, 0);
      send_request(FUNC_FREE, 1, 1, 2047, MASK52);
      send_request(FUNC_ALLOC, 1, 0, 1024, 0);
      send_request(FUNC_FREE, 0, 0, 8, 4);
      send_request(FUNC_FREE, 0, 0, 6, 110);
      hold_request = 1;
      random_items(220);
      drain();
      random_items(10);

      // Kernel bits freed above stay free, so grants now wrap past the top.
      configure(MASK52 - 3, 32, 0, 8);
      send_request(FUNC_ALLOC, 0, 1, 6, 0);
      random_items(200);

      configure(5000, 2047, 3000, 1024);
      random_items(220);

      configure(0, 0, MASK52, 20);
      send_request(FUNC_FREE, 1, 0, 1, MASK52);
      random_items(200);

      configure(10, 20, 15, 40);
      random_items(200);

      configure(MASK52, 1024, 0, 1);
      random_items(150);

      drain();
      repeat (30) @(posedge clock);
      if (sb.errors == 0 && sb.pending_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
